// ===== rtl/swg_pkg.sv =====
package swg_pkg;

	// default build
	localparam int GRID_CELLS_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// port field widths
	localparam int COL_W     = 6;
	localparam int TEX_W     = 18;
	localparam int REG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int OUT_FRAC  = 16;

	// output clamp range, signed q2.16
	localparam int SAT_MAX = 131071;
	localparam int SAT_MIN = -131072;

	// configuration register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X     = 2'd0,
		REG_CENTER_Y     = 2'd1,
		REG_SWIRL_RADIUS = 2'd2
	} cfg_reg_t;

	localparam logic [REG_W-1:0] CENTER_RST = 16'd32768;
	localparam logic [REG_W-1:0] RADIUS_RST = 16'd26214;

	// turn based cordic, q30 amplitude, angles in 2^-32 turn
	localparam int CORDIC_W   = 32;
	localparam int CORDIC_MAX = 28;
	localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = 32'sd652032874;

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic signed [CORDIC_W-1:0] turn_atan(input int i);
		logic signed [CORDIC_W-1:0] a;
		unique case (i)
			0: a = 32'sd536870912;
			1: a = 32'sd316933406;
			2: a = 32'sd167458907;
			3: a = 32'sd85004756;
			4: a = 32'sd42667331;
			5: a = 32'sd21354465;
			6: a = 32'sd10679838;
			7: a = 32'sd5340245;
			8: a = 32'sd2670163;
			9: a = 32'sd1335087;
			10: a = 32'sd667544;
			11: a = 32'sd333772;
			12: a = 32'sd166886;
			13: a = 32'sd83443;
			14: a = 32'sd41722;
			15: a = 32'sd20861;
			16: a = 32'sd10430;
			17: a = 32'sd5215;
			18: a = 32'sd2608;
			19: a = 32'sd1304;
			20: a = 32'sd652;
			21: a = 32'sd326;
			22: a = 32'sd163;
			23: a = 32'sd81;
			24: a = 32'sd41;
			25: a = 32'sd20;
			26: a = 32'sd10;
			27: a = 32'sd5;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// ===== rtl/swg_ifs.sv =====
// grid point channel
interface swg_point_if;
	logic                      valid;
	logic                      ready;
	logic [swg_pkg::COL_W-1:0] grid_col;
	logic [swg_pkg::COL_W-1:0] grid_row;
	modport source(output valid, grid_col, grid_row, input ready);
	modport sink(input valid, grid_col, grid_row, output ready);
endinterface

// warped coordinate channel
interface swg_coord_if;
	logic                             valid;
	logic                             ready;
	logic signed [swg_pkg::TEX_W-1:0] tex_u;
	logic signed [swg_pkg::TEX_W-1:0] tex_v;
	modport source(output valid, tex_u, tex_v, input ready);
	modport sink(input valid, tex_u, tex_v, output ready);
endinterface

// register write channel
interface swg_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [swg_pkg::CFG_IDX_W-1:0] index;
	logic [swg_pkg::REG_W-1:0]     data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/swg_isqrt.sv =====
module swg_isqrt #(
	parameter int FRAC_BITS = swg_pkg::FRAC_BITS_DEF,
	parameter int SBW       = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_vld,
	input  logic [2*FRAC_BITS+1:0] in_sq,
	input  logic [SBW-1:0]         in_side,
	output logic                   out_vld,
	output logic [FRAC_BITS:0]     out_root,
	output logic [SBW-1:0]         out_side
);
	import swg_pkg::*;

	localparam int K  = FRAC_BITS + 1;
	localparam int SW = 2 * FRAC_BITS + 2;

	logic           vld_s  [K];
	logic [SW-1:0]  rem_s  [K];
	logic [SW-1:0]  res_s  [K];
	logic [SBW-1:0] side_s [K];

	// one result bit per stage
	for (genvar k = 0; k < K; k++) begin : g_step
		localparam logic [SW-1:0] BIT = SW'(1) << (2 * (K - 1 - k));
		logic           vld_in;
		logic [SW-1:0]  rem_in;
		logic [SW-1:0]  res_in;
		logic [SBW-1:0] side_in;
		logic [SW-1:0]  trial;

		if (k == 0) begin : g_first
			assign vld_in  = in_vld;
			assign rem_in  = in_sq;
			assign res_in  = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign res_in  = res_s[k-1];
			assign side_in = side_s[k-1];
		end

		assign trial = res_in + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= side_in;
				if (rem_in >= trial) begin
					rem_s[k] <= rem_in - trial;
					res_s[k] <= (res_in >> 1) + BIT;
				end else begin
					rem_s[k] <= rem_in;
					res_s[k] <= res_in >> 1;
				end
			end
		end
	end

	assign out_vld  = vld_s[K-1];
	assign out_root = res_s[K-1][FRAC_BITS:0];
	assign out_side = side_s[K-1];

endmodule

// ===== rtl/swg_div.sv =====
module swg_div #(
	parameter int FRAC_BITS = swg_pkg::FRAC_BITS_DEF,
	parameter int SBW       = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [FRAC_BITS-1:0] rad,
	input  logic                 in_vld,
	input  logic                 in_inner,
	input  logic [FRAC_BITS:0]   in_root,
	input  logic [SBW-1:0]       in_side,
	output logic                 out_vld,
	output logic                 out_take,
	output logic [FRAC_BITS-1:0] out_s,
	output logic [SBW-1:0]       out_side
);
	import swg_pkg::*;

	localparam int F = FRAC_BITS;

	logic             vld_s1, take_s1;
	logic [F-1:0]     diff_s1;
	logic [SBW-1:0]   side_s1;
	logic             vld_s2, take_s2;
	logic [2*F-1:0]   sq_s2;
	logic [SBW-1:0]   side_s2;
	logic             take_c;

	// swirl applies only to inner points within a nonzero radius
	assign take_c = in_inner && (rad != '0) && (in_root <= {1'b0, rad});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	// distance to the rim, then its square
	always_ff @(posedge clk) begin
		if (en) begin
			take_s1 <= take_c;
			diff_s1 <= take_c ? rad - in_root[F-1:0] : '0;
			side_s1 <= in_side;
			take_s2 <= take_s1;
			sq_s2   <= diff_s1 * diff_s1;
			side_s2 <= side_s1;
		end
	end

	// restoring division by the radius, one quotient bit per stage
	logic           vld_s  [F];
	logic           take_s [F];
	logic [F-1:0]   rem_s  [F];
	logic [F-1:0]   quo_s  [F];
	logic [F-1:0]   lo_s   [F];
	logic [SBW-1:0] side_s [F];

	for (genvar j = 0; j < F; j++) begin : g_step
		logic           vld_in, take_in;
		logic [F-1:0]   rem_in, quo_in, lo_in;
		logic [SBW-1:0] side_in;
		logic [F:0]     trial;

		if (j == 0) begin : g_first
			assign vld_in  = vld_s2;
			assign take_in = take_s2;
			assign rem_in  = sq_s2[2*F-1:F];
			assign quo_in  = '0;
			assign lo_in   = sq_s2[F-1:0];
			assign side_in = side_s2;
		end else begin : g_next
			assign vld_in  = vld_s[j-1];
			assign take_in = take_s[j-1];
			assign rem_in  = rem_s[j-1];
			assign quo_in  = quo_s[j-1];
			assign lo_in   = lo_s[j-1];
			assign side_in = side_s[j-1];
		end

		assign trial = {rem_in, lo_in[F-1-j]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				take_s[j] <= take_in;
				lo_s[j]   <= lo_in;
				side_s[j] <= side_in;
				if (trial >= {1'b0, rad}) begin
					rem_s[j] <= F'(trial - {1'b0, rad});
					quo_s[j] <= {quo_in[F-2:0], 1'b1};
				end else begin
					rem_s[j] <= trial[F-1:0];
					quo_s[j] <= {quo_in[F-2:0], 1'b0};
				end
			end
		end
	end

	assign out_vld  = vld_s[F-1];
	assign out_take = take_s[F-1];
	assign out_s    = quo_s[F-1];
	assign out_side = side_s[F-1];

endmodule

// ===== rtl/swg_cordic.sv =====
module swg_cordic #(
	parameter int FRAC_BITS = swg_pkg::FRAC_BITS_DEF,
	parameter int SBW       = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_vld,
	input  logic [FRAC_BITS-1:0]                  in_s,
	input  logic [SBW-1:0]                        in_side,
	output logic                                  out_vld,
	output logic signed [swg_pkg::CORDIC_W-1:0]   out_co,
	output logic signed [swg_pkg::CORDIC_W-1:0]   out_si,
	output logic [SBW-1:0]                        out_side
);
	import swg_pkg::*;

	localparam int N  = (FRAC_BITS + 4 < CORDIC_MAX) ? FRAC_BITS + 4 : CORDIC_MAX;
	localparam int XW = CORDIC_W;

	logic [XW-1:0]          angle;
	logic signed [XW-1:0]   z0;

	// angle in 2^-32 turn; top two bits pick the quadrant
	assign angle = XW'(in_s) << (XW - FRAC_BITS);
	assign z0    = signed'({2'b00, angle[XW-3:0]});

	logic                 vld_s  [N];
	logic signed [XW-1:0] x_s    [N];
	logic signed [XW-1:0] y_s    [N];
	logic signed [XW-1:0] z_s    [N];
	quad_t                quad_s [N];
	logic [SBW-1:0]       side_s [N];

	// one micro-rotation per stage
	for (genvar i = 0; i < N; i++) begin : g_rot
		logic                 vld_in;
		logic signed [XW-1:0] x_in, y_in, z_in, xs, ys;
		quad_t                quad_in;
		logic [SBW-1:0]       side_in;

		if (i == 0) begin : g_first
			assign vld_in  = in_vld;
			assign x_in    = GAIN_Q30;
			assign y_in    = '0;
			assign z_in    = z0;
			assign quad_in = quad_t'(angle[XW-1:XW-2]);
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[i-1];
			assign x_in    = x_s[i-1];
			assign y_in    = y_s[i-1];
			assign z_in    = z_s[i-1];
			assign quad_in = quad_s[i-1];
			assign side_in = side_s[i-1];
		end

		assign xs = x_in >>> i;
		assign ys = y_in >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quad_s[i] <= quad_in;
				side_s[i] <= side_in;
				if (!z_in[XW-1]) begin
					x_s[i] <= x_in - ys;
					y_s[i] <= y_in + xs;
					z_s[i] <= z_in - turn_atan(i);
				end else begin
					x_s[i] <= x_in + ys;
					y_s[i] <= y_in - xs;
					z_s[i] <= z_in + turn_atan(i);
				end
			end
		end
	end

	// exact quarter turn
	logic                 vld_sf;
	logic signed [XW-1:0] co_sf, si_sf, co_c, si_c;
	logic [SBW-1:0]       side_sf;

	always_comb begin
		unique case (quad_s[N-1])
			QUAD_1: begin
				co_c = -y_s[N-1];
				si_c = x_s[N-1];
			end
			QUAD_2: begin
				co_c = -x_s[N-1];
				si_c = -y_s[N-1];
			end
			QUAD_3: begin
				co_c = y_s[N-1];
				si_c = -x_s[N-1];
			end
			default: begin
				co_c = x_s[N-1];
				si_c = y_s[N-1];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sf <= 1'b0;
		end else if (en) begin
			vld_sf <= vld_s[N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			co_sf   <= co_c;
			si_sf   <= si_c;
			side_sf <= side_s[N-1];
		end
	end

	assign out_vld  = vld_sf;
	assign out_co   = co_sf;
	assign out_si   = si_sf;
	assign out_side = side_sf;

endmodule

// ===== rtl/swirl_grid_warp.sv =====
// swirl warp of a regular grid, one grid point per transaction.
// point channel: grid_col, grid_row give a grid point (0..GRID_CELLS);
// coord channel: tex_u, tex_v give the warped texture coordinate, signed q2.16.
// cfg channel: index 0 center_x, 1 center_y, 2 swirl_radius, 16-bit data;
// it is always ready and writes are registered. write only while idle.
// unknown indexes are dropped.
// from point acceptance to coord valid a point passes the front stages,
// the square root (FRAC_BITS+1 stages), the radius divide (FRAC_BITS+2),
// the cordic (one stage per rotation plus the quadrant stage), the back
// stages and the output register.
// throughput: one point per clock while point.ready is high. the whole pipeline
// moves on one enable; the output register has a one-entry skid behind it,
// and point.ready is low only while that skid entry is occupied, so a stalled
// receiver backs the pipeline up without losing or repeating a transaction.
// reset: all valid bits clear, the registers return to center 0.5, 0.5 and
// radius 0.4; point.ready is high right after reset.
module swirl_grid_warp #(
	parameter int GRID_CELLS = swg_pkg::GRID_CELLS_DEF,
	parameter int FRAC_BITS  = swg_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	swg_cfg_if.sink     cfg,
	swg_point_if.sink   point,
	swg_coord_if.source coord
);
	import swg_pkg::*;

	localparam int F   = FRAC_BITS;
	localparam int PW  = F + 6;
	localparam int CW  = F + 1;
	localparam int SW  = 2 * F + 2;
	localparam int XW  = CORDIC_W;
	localparam int MW  = CW + XW;
	localparam int PRW = MW + 1;
	localparam int UW  = F + 3;
	localparam int FW  = F + 7;
	localparam int OW  = F + 13;
	localparam int SB2 = 2 * PW + 2 * CW;
	localparam int SB1 = SB2 + 1;
	localparam int SB3 = SB2 + 1;
	localparam int SHR = (F > OUT_FRAC) ? F - OUT_FRAC : 0;
	localparam int SHL = (F < OUT_FRAC) ? OUT_FRAC - F : 0;
	localparam int RND_O = (F > OUT_FRAC) ? 1 << (F - OUT_FRAC - 1) : 0;
	localparam logic [8:0] EDGE_LO = 9'd2;
	localparam logic [8:0] EDGE_HI = 9'(GRID_CELLS - 2);
	localparam logic signed [PRW-1:0] RND_P = PRW'(1) << 29;
	localparam logic signed [OW-1:0]  SAT_HI = OW'(SAT_MAX);
	localparam logic signed [OW-1:0]  SAT_LO = OW'(SAT_MIN);

	// configuration registers
	logic [REG_W-1:0] center_x_q, center_y_q, radius_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= CENTER_RST;
			center_y_q <= CENTER_RST;
			radius_q   <= RADIUS_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_CENTER_X:     center_x_q <= cfg.data;
				REG_CENTER_Y:     center_y_q <= cfg.data;
				REG_SWIRL_RADIUS: radius_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// registers at FRAC_BITS precision
	logic [F-1:0] wx, wy, rad;

	if (F >= REG_W) begin : g_fix_up
		assign wx  = F'(center_x_q) << (F - REG_W);
		assign wy  = F'(center_y_q) << (F - REG_W);
		assign rad = F'(radius_q) << (F - REG_W);
	end else begin : g_fix_dn
		assign wx  = F'(center_x_q >> (REG_W - F));
		assign wy  = F'(center_y_q >> (REG_W - F));
		assign rad = F'(radius_q >> (REG_W - F));
	end

	// grid index to position, index * 2^F / GRID_CELLS
	logic [PW-1:0] pos_tab [2**COL_W];

	for (genvar i = 0; i < 2**COL_W; i++) begin : g_pos
		localparam longint POS = (longint'(i) << F) / GRID_CELLS;
		assign pos_tab[i] = PW'(POS);
	end

	// pipeline enable: everything moves while the skid entry is free
	logic en, res_vld_q, skid_vld_q;

	assign en          = !skid_vld_q;
	assign point.ready = en;

	logic [8:0] col9, row9;

	assign col9 = 9'(point.grid_col);
	assign row9 = 9'(point.grid_row);

	// front stages: position, offset, squares, sum
	logic                 vld_s1, vld_s2, vld_s3, vld_s4;
	logic                 inner_s1, inner_s2, inner_s3, inner_s4;
	logic [PW-1:0]        px_s1, py_s1, px_s2, py_s2, px_s3, py_s3, px_s4, py_s4;
	logic signed [CW-1:0] cx_s2, cy_s2, cx_s3, cy_s3, cx_s4, cy_s4;
	logic signed [SW-1:0] sqx_s3, sqy_s3, sum_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= point.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1    <= pos_tab[point.grid_col];
			py_s1    <= pos_tab[point.grid_row];
			inner_s1 <= (col9 >= EDGE_LO) && (col9 <= EDGE_HI) &&
			            (row9 >= EDGE_LO) && (row9 <= EDGE_HI);
			px_s2    <= px_s1;
			py_s2    <= py_s1;
			inner_s2 <= inner_s1;
			cx_s2    <= signed'(CW'(px_s1) - CW'(wx));
			cy_s2    <= signed'(CW'(py_s1) - CW'(wy));
			px_s3    <= px_s2;
			py_s3    <= py_s2;
			inner_s3 <= inner_s2;
			cx_s3    <= cx_s2;
			cy_s3    <= cy_s2;
			sqx_s3   <= cx_s2 * cx_s2;
			sqy_s3   <= cy_s2 * cy_s2;
			px_s4    <= px_s3;
			py_s4    <= py_s3;
			inner_s4 <= inner_s3;
			cx_s4    <= cx_s3;
			cy_s4    <= cy_s3;
			sum_s4   <= sqx_s3 + sqy_s3;
		end
	end

	// distance
	logic           sq_vld;
	logic [F:0]     root;
	logic [SB1-1:0] sq_side;
	logic           sq_inner;
	logic [SB2-1:0] sq_rest;

	swg_isqrt #(
		.FRAC_BITS (F),
		.SBW       (SB1)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s4),
		.in_sq    (sum_s4),
		.in_side  ({inner_s4, px_s4, py_s4, cx_s4, cy_s4}),
		.out_vld  (sq_vld),
		.out_root (root),
		.out_side (sq_side)
	);

	assign {sq_inner, sq_rest} = sq_side;

	// swirl amount in turns
	logic           dv_vld, dv_take;
	logic [F-1:0]   dv_s;
	logic [SB2-1:0] dv_side;

	swg_div #(
		.FRAC_BITS (F),
		.SBW       (SB2)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.rad      (rad),
		.in_vld   (sq_vld),
		.in_inner (sq_inner),
		.in_root  (root),
		.in_side  (sq_rest),
		.out_vld  (dv_vld),
		.out_take (dv_take),
		.out_s    (dv_s),
		.out_side (dv_side)
	);

	// sine and cosine
	logic                 cr_vld;
	logic signed [XW-1:0] co, si;
	logic [SB3-1:0]       cr_side;
	logic                 take_c;
	logic [PW-1:0]        px_c, py_c;
	logic signed [CW-1:0] cx_c, cy_c;

	swg_cordic #(
		.FRAC_BITS (F),
		.SBW       (SB3)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (dv_vld),
		.in_s     (dv_s),
		.in_side  ({dv_take, dv_side}),
		.out_vld  (cr_vld),
		.out_co   (co),
		.out_si   (si),
		.out_side (cr_side)
	);

	assign {take_c, px_c, py_c, cx_c, cy_c} = cr_side;

	// back stages: products, rounded sums, centre add, output format
	logic                  vld_s5, vld_s6, vld_s7, vld_s8;
	logic                  take_s5, take_s6;
	logic [PW-1:0]         px_s5, py_s5, px_s6, py_s6;
	logic signed [MW-1:0]  pxc_s5, pys_s5, pyc_s5, pxs_s5;
	logic signed [UW-1:0]  rot_u_s6, rot_v_s6;
	logic signed [FW-1:0]  fin_u_s7, fin_v_s7;
	logic [TEX_W-1:0]      tex_u_s8, tex_v_s8;
	logic signed [PRW-1:0] u_full, v_full;
	logic signed [FW-1:0]  fin_u_c, fin_v_c;

	always_comb begin
		u_full = (PRW'(pxc_s5) + PRW'(pys_s5) + RND_P) >>> 30;
		v_full = (PRW'(pyc_s5) - PRW'(pxs_s5) + RND_P) >>> 30;
		if (take_s6) begin
			fin_u_c = FW'(signed'({1'b0, wx})) + FW'(rot_u_s6);
			fin_v_c = FW'(signed'({1'b0, wy})) + FW'(rot_v_s6);
		end else begin
			fin_u_c = FW'(signed'({1'b0, px_s6}));
			fin_v_c = FW'(signed'({1'b0, py_s6}));
		end
	end

	// round or scale to q2.16 and clamp
	function automatic logic [TEX_W-1:0] to_out(input logic signed [FW-1:0] f);
		logic signed [OW-1:0] o;
		o = ((OW'(f) + OW'(RND_O)) >>> SHR) <<< SHL;
		if (o > SAT_HI) begin
			o = SAT_HI;
		end else if (o < SAT_LO) begin
			o = SAT_LO;
		end
		return o[TEX_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s5 <= cr_vld;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			take_s5  <= take_c;
			px_s5    <= px_c;
			py_s5    <= py_c;
			pxc_s5   <= cx_c * co;
			pys_s5   <= cy_c * si;
			pyc_s5   <= cy_c * co;
			pxs_s5   <= cx_c * si;
			take_s6  <= take_s5;
			px_s6    <= px_s5;
			py_s6    <= py_s5;
			rot_u_s6 <= u_full[UW-1:0];
			rot_v_s6 <= v_full[UW-1:0];
			fin_u_s7 <= fin_u_c;
			fin_v_s7 <= fin_v_c;
			tex_u_s8 <= to_out(fin_u_s7);
			tex_v_s8 <= to_out(fin_v_s7);
		end
	end

	// output register with one skid entry
	logic [TEX_W-1:0] res_u_q, res_v_q, skid_u_q, skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (en) begin
			if (vld_s8) begin
				if (!res_vld_q || coord.ready) begin
					res_vld_q <= 1'b1;
				end else begin
					skid_vld_q <= 1'b1;
				end
			end else if (coord.ready) begin
				res_vld_q <= 1'b0;
			end
		end else if (coord.ready) begin
			skid_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (vld_s8 && (!res_vld_q || coord.ready)) begin
				res_u_q <= tex_u_s8;
				res_v_q <= tex_v_s8;
			end else if (vld_s8) begin
				skid_u_q <= tex_u_s8;
				skid_v_q <= tex_v_s8;
			end
		end else if (coord.ready) begin
			res_u_q <= skid_u_q;
			res_v_q <= skid_v_q;
		end
	end

	assign coord.valid = res_vld_q;
	assign coord.tex_u = signed'(res_u_q);
	assign coord.tex_v = signed'(res_v_q);

	// the skid entry is only ever behind a held output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> res_vld_q)
		else $error("skid entry occupied with empty output register");

	// the skid entry fills only when the output was stalled
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(res_vld_q && !coord.ready && vld_s8))
		else $error("skid entry filled without a stalled output");

	// a drained skid entry moves to the output and frees the pipeline
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && coord.ready |=> res_vld_q && !skid_vld_q)
		else $error("skid entry not drained into the output register");

endmodule

// ===== test/swirl_grid_warp_tb.sv =====
`timescale 1ns / 1ps

module swirl_grid_warp_tb;
	import swg_pkg::*;

	localparam int GRID  = GRID_CELLS_DEF;
	localparam int FRAC  = FRAC_BITS_DEF;
	localparam int LAT   = 2 * FRAC + ((FRAC + 4 < CORDIC_MAX) ? FRAC + 4 : CORDIC_MAX) + 13;

	typedef struct packed {
		logic signed [TEX_W-1:0] u;
		logic signed [TEX_W-1:0] v;
	} coord_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	swg_cfg_if   cfg();
	swg_point_if point();
	swg_coord_if coord();

	swirl_grid_warp dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg.sink),
		.point(point.sink),
		.coord(coord.source)
	);

	always #5 clk = ~clk;

	// predictor copy of the registers
	logic [REG_W-1:0] ctr_x, ctr_y, radius;
	coord_t warp_q[$];
	int errors = 0;
	int send_idle = 0;
	int recv_stall = 0;
	bit hold_off = 0;

	function automatic longint fshr(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint to_fix(logic [REG_W-1:0] r);
		longint x = r;
		if (FRAC >= 16) return x << (FRAC - 16);
		return x >> (16 - FRAC);
	endfunction

	function automatic longint root_floor(longint unsigned a);
		longint unsigned res = 0;
		longint unsigned b = 64'd1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (a >= res + b) begin
				a = a - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return longint'(res);
	endfunction

	function automatic logic signed [TEX_W-1:0] to_q216(longint v);
		longint o;
		if (FRAC > 16) o = fshr(v + (64'sd1 << (FRAC - 17)), FRAC - 16);
		else o = v * (64'sd1 << (16 - FRAC));
		if (o > SAT_MAX) o = SAT_MAX;
		if (o < SAT_MIN) o = SAT_MIN;
		return o[TEX_W-1:0];
	endfunction

	// turn based sine and cosine in q30
	task automatic turn_sincos(input longint unsigned ang, output longint co, output longint si);
		quad_t q;
		longint z, x, y, t, xs, ys;
		q = quad_t'(ang[31:30]);
		z = ang & 64'h3FFF_FFFF;
		x = GAIN_Q30;
		y = 0;
		for (int i = 0; i < FRAC + 4 && i < CORDIC_MAX; i++) begin
			xs = fshr(x, i);
			ys = fshr(y, i);
			if (z >= 0) begin
				x = x - ys; y = y + xs; z = z - longint'(turn_atan(i));
			end else begin
				x = x + ys; y = y - xs; z = z + longint'(turn_atan(i));
			end
		end
		unique case (q)
			QUAD_1: begin t = x; x = -y; y = t; end
			QUAD_2: begin x = -x; y = -y; end
			QUAD_3: begin t = x; x = y; y = -t; end
			default: ;
		endcase
		co = x;
		si = y;
	endtask

	task automatic swirl_predict(input int col, input int row, output coord_t res);
		longint px, py, wx, wy, r, cx, cy, d, df, s, co, si, u, v;
		longint unsigned ang;
		px = (longint'(col) << FRAC) / GRID;
		py = (longint'(row) << FRAC) / GRID;
		res.u = to_q216(px);
		res.v = to_q216(py);
		if (col <= 1 || col >= GRID - 1 || row <= 1 || row >= GRID - 1) return;
		wx = to_fix(ctr_x);
		wy = to_fix(ctr_y);
		r = to_fix(radius);
		cx = px - wx;
		cy = py - wy;
		d = root_floor(longint'(cx * cx + cy * cy));
		if (r == 0 || d > r) return;
		df = r - d;
		s = (df * df) / r;
		ang = (longint'(s) << (32 - FRAC)) & 64'hFFFF_FFFF;
		turn_sincos(ang, co, si);
		u = fshr(cx * co + cy * si + (64'sd1 << 29), 30);
		v = fshr(cy * co - cx * si + (64'sd1 << 29), 30);
		res.u = to_q216(wx + u);
		res.v = to_q216(wy + v);
	endtask

	// one point transaction; valid stays up until an idle gap or a drain
	task automatic send_point(input int col, input int row);
		coord_t e;
		int gap;
		gap = 0;
		if (send_idle > 0) while ($urandom_range(99, 0) < send_idle && gap < 20) begin
			point.valid <= 1'b0;
			gap++;
			@(posedge clk);
		end
		point.valid <= 1'b1;
		point.grid_col <= col[COL_W-1:0];
		point.grid_row <= row[COL_W-1:0];
		swirl_predict(col, row, e);
		warp_q.push_back(e);
		@(posedge clk);
		while (!point.ready) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [REG_W-1:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		unique case (idx)
			REG_CENTER_X: ctr_x = val;
			REG_CENTER_Y: ctr_y = val;
			REG_SWIRL_RADIUS: radius = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain();
		point.valid <= 1'b0;
		while (warp_q.size() != 0) @(posedge clk);
		repeat (LAT + 4) @(posedge clk);
	endtask

	// receiver stall
	always @(posedge clk) begin
		if (!arst_n) coord.ready <= 1'b0;
		else coord.ready <= !hold_off && ($urandom_range(99, 0) >= recv_stall);
	end

	// result checker
	always @(posedge clk) begin
		coord_t e;
		if (arst_n && coord.valid && coord.ready) begin
			if (warp_q.size() == 0) begin
				$error("coord transaction with nothing expected");
				errors++;
			end else begin
				e = warp_q.pop_front();
				if (coord.tex_u !== e.u) begin
					$error("tex_u expected %0d actual %0d", e.u, coord.tex_u);
					errors++;
				end
				if (coord.tex_v !== e.v) begin
					$error("tex_v expected %0d actual %0d", e.v, coord.tex_v);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		int pts[$] = '{0, 1, 2, 16, 30, 31, 32, 33, 63};
		foreach (pts[i]) send_point(pts[i], 16);
		foreach (pts[i]) send_point(16, pts[i]);
		send_point(17, 15);
		send_point(14, 18);
		send_point(10, 10);
		send_point(22, 22);
		send_point(5, 28);
		drain();
	endtask

	task automatic random_points(input int n);
		int c, r;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9, 0) == 0) begin
				c = $urandom_range(63, 0);
				r = $urandom_range(63, 0);
			end else begin
				c = $urandom_range(GRID, 0);
				r = $urandom_range(GRID, 0);
			end
			send_point(c, r);
		end
	endtask

	task automatic test_config_sweep();
		write_reg(REG_CENTER_X, 16'd0);
		write_reg(REG_CENTER_Y, 16'hFFFF);
		write_reg(REG_SWIRL_RADIUS, 16'hFFFF);
		random_points(150);
		drain();
		write_reg(REG_CENTER_X, 16'hFFFF);
		write_reg(REG_CENTER_Y, 16'd0);
		write_reg(REG_SWIRL_RADIUS, 16'd1);
		random_points(100);
		drain();
		write_reg(REG_CENTER_X, 16'd20000);
		write_reg(REG_CENTER_Y, 16'd41000);
		write_reg(REG_SWIRL_RADIUS, 16'd0);
		random_points(80);
		drain();
		write_reg(REG_CENTER_X, CENTER_RST);
		write_reg(REG_CENTER_Y, CENTER_RST);
		write_reg(REG_SWIRL_RADIUS, RADIUS_RST);
	endtask

	task automatic test_idle_phases();
		int sendp[4] = '{0, 81, 0, 16};
		int recvp[4] = '{0, 0, 81, 16};
		for (int p = 0; p < 4; p++) begin
			send_idle = sendp[p];
			recv_stall = recvp[p];
			write_reg(REG_CENTER_X, 16'($urandom));
			write_reg(REG_CENTER_Y, 16'($urandom));
			write_reg(REG_SWIRL_RADIUS, 16'($urandom_range(65535, 1)));
			random_points(p == 0 ? 500 : 200);
			drain();
		end
		send_idle = 0;
		recv_stall = 0;
	endtask

	// receiver blocked while points keep coming
	task automatic test_backpressure();
		fork
			begin
				hold_off = 1;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			random_points(200);
		join
		drain();
		random_points(30);
		drain();
	endtask

	initial begin
		point.valid = 1'b0;
		point.grid_col = '0;
		point.grid_row = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_CENTER_X;
		cfg.data = '0;
		ctr_x = CENTER_RST;
		ctr_y = CENTER_RST;
		radius = RADIUS_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_sweep();
		test_idle_phases();
		test_backpressure();
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
